[hdl/tsdf_pkg.sv]
// Shared types, constants and register codes for the torus distance grid sampler.
package tsdf_pkg;

  localparam int MAX_DIM     = 64;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int SIZE_W      = 7;
  localparam int ADDR_W      = 18;
  localparam int SYZ_W       = 2 * SIZE_W - 1;
  localparam int SQRT_STAGES = 16;
  localparam int LINE_LEN    = 2 * SQRT_STAGES + 5;

  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_STEP       = 3'd3,
    REG_RESOLUTION = 3'd4,
    REG_SIZE_X     = 3'd5,
    REG_SIZE_Y     = 3'd6,
    REG_SIZE_Z     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [30:0]        step;
    logic [30:0]        resolution;
    logic [SIZE_W-1:0]  eff_x;
    logic [SIZE_W-1:0]  eff_y;
    logic [SIZE_W-1:0]  eff_z;
    logic [SYZ_W-1:0]   syz;
    logic [27:0]        small_r;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              oor;
    logic [63:0]       sqz;
  } side_t;

endpackage

[hdl/tsdf_regs.sv]
// Configuration register file with derived size product and minor radius.
module tsdf_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output tsdf_pkg::cfg_t      cfg
);
  import tsdf_pkg::*;

  logic signed [31:0] origin_x, origin_y, origin_z;
  logic [30:0]        step, resolution;
  logic [SIZE_W-1:0]  size_x, size_y, size_z;
  logic [SIZE_W-1:0]  eff_x, eff_y, eff_z;
  logic [SYZ_W-1:0]   syz;
  logic [27:0]        small_r;
  logic [62:0]        recip_prod;
  logic               wr;
  reg_idx_t           idx;

  assign wr  = psel & penable & pwrite;
  assign idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      origin_z   <= '0;
      step       <= 31'd65536;
      resolution <= 31'd4194304;
      size_x     <= SIZE_W'(MAX_DIM);
      size_y     <= SIZE_W'(MAX_DIM);
      size_z     <= SIZE_W'(MAX_DIM);
    end else if (wr) begin
      case (idx)
        REG_ORIGIN_X:   origin_x   <= pwdata;
        REG_ORIGIN_Y:   origin_y   <= pwdata;
        REG_ORIGIN_Z:   origin_z   <= pwdata;
        REG_STEP:       step       <= pwdata[30:0];
        REG_RESOLUTION: resolution <= pwdata[30:0];
        REG_SIZE_X:     size_x     <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y:     size_y     <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z:     size_z     <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_x = (size_x > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_x;
    eff_y = (size_y > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_y;
    eff_z = (size_z > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_z;
    recip_prod = {32'd0, resolution} * {31'd0, RECIP_TEN};
  end

  // Division by ten is a reciprocal multiply, exact for any 32-bit value.
  always_ff @(posedge clk) begin
    syz     <= SYZ_W'({6'd0, eff_y} * {6'd0, eff_z});
    small_r <= recip_prod[62:35];
  end

  always_comb begin
    case (idx)
      REG_ORIGIN_X:   prdata = origin_x;
      REG_ORIGIN_Y:   prdata = origin_y;
      REG_ORIGIN_Z:   prdata = origin_z;
      REG_STEP:       prdata = {1'b0, step};
      REG_RESOLUTION: prdata = {1'b0, resolution};
      REG_SIZE_X:     prdata = {25'd0, size_x};
      REG_SIZE_Y:     prdata = {25'd0, size_y};
      REG_SIZE_Z:     prdata = {25'd0, size_z};
      default:        prdata = '0;
    endcase
  end

  assign cfg = '{origin_x: origin_x, origin_y: origin_y, origin_z: origin_z,
                 step: step, resolution: resolution,
                 eff_x: eff_x, eff_y: eff_y, eff_z: eff_z,
                 syz: syz, small_r: small_r};
endmodule

[hdl/tsdf_point.sv]
// Sample point, flat address and range flag stage.
module tsdf_point (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [tsdf_pkg::IDX_W-1:0]  gx,
  input  logic [tsdf_pkg::IDX_W-1:0]  gy,
  input  logic [tsdf_pkg::IDX_W-1:0]  gz,
  input  tsdf_pkg::cfg_t              cfg,
  output logic                        out_valid,
  output logic signed [31:0]          px,
  output logic signed [31:0]          py,
  output logic signed [31:0]          pz,
  output logic [tsdf_pkg::ADDR_W-1:0] addr,
  output logic                        oor
);
  import tsdf_pkg::*;

  function automatic logic signed [31:0] coord(input logic signed [31:0] org,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [30:0] stp);
    logic signed [38:0] p;
    p = 39'(org) + $signed({2'b00, {31'd0, idx} * {6'd0, stp}});
    if (p > 39'sh0_7FFF_FFFF)       coord = 32'sh7FFF_FFFF;
    else if (p < -39'sh0_8000_0000) coord = 32'sh8000_0000;
    else                            coord = p[31:0];
  endfunction

  logic [18:0] addr_sum;

  assign addr_sum = 19'({13'd0, gx} * {6'd0, cfg.syz}) +
                    19'({13'd0, gy} * {12'd0, cfg.eff_z}) + 19'(gz);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    px   <= coord(cfg.origin_x, gx, cfg.step);
    py   <= coord(cfg.origin_y, gy, cfg.step);
    pz   <= coord(cfg.origin_z, gz, cfg.step);
    addr <= addr_sum[ADDR_W-1:0];
    oor  <= ({1'b0, gx} >= cfg.eff_x) || ({1'b0, gy} >= cfg.eff_y) ||
            ({1'b0, gz} >= cfg.eff_z);
  end
endmodule

[hdl/tsdf_sqrt.sv]
// Pipelined floor square root of a 64-bit value, two result bits per stage.
module tsdf_sqrt (
  input  logic        clk,
  input  logic [63:0] din,
  output logic [31:0] root
);
  import tsdf_pkg::*;

  logic [34:0] rem_q  [SQRT_STAGES];
  logic [31:0] root_q [SQRT_STAGES];
  logic [63:0] n_q    [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [34:0] r_in;
    logic [31:0] q_in;
    logic [63:0] m_in;
    logic [34:0] r;
    logic [31:0] q;
    logic [63:0] m;
    logic [34:0] t;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign m_in = din;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign q_in = root_q[s-1];
      assign m_in = n_q[s-1];
    end

    always_comb begin
      r = r_in;
      q = q_in;
      m = m_in;
      t = '0;
      for (int k = 0; k < 2; k++) begin
        r = {r[32:0], m[63:62]};
        m = {m[61:0], 2'b00};
        t = {1'b0, q, 2'b01};
        if (r >= t) begin
          r = r - t;
          q = {q[30:0], 1'b1};
        end else begin
          q = {q[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s]  <= r;
      root_q[s] <= q;
      n_q[s]    <= m;
    end
  end

  assign root = root_q[SQRT_STAGES-1];
endmodule

[hdl/torus_sdf_grid_sampler_top.sv]
// Top level of the torus signed distance grid sampler pipeline.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  request  | start, busy (always 0) | grid_x, grid_y, grid_z
//  result   | done (one-cycle pulse) | sample_value, sample_address,
//           |                        | index_out_of_range
//  config   | psel, penable, pwrite  | paddr, pwdata, prdata, pready (always 1)
//
// A new request may be issued on every clock cycle; busy never rises.
// Each result is registered on the ports together with done; its path runs through
// the two 16-stage square root pipelines plus the capture, point, square and radius
// stages around them.
// Results leave in request order, one per request.
// The synchronous reset clears the valid bits of every stage and restores the
// register defaults. The receiver cannot stall, so nothing in the pipeline
// ever holds.
module torus_sdf_grid_sampler_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [tsdf_pkg::IDX_W-1:0]  grid_x,
  input  logic [tsdf_pkg::IDX_W-1:0]  grid_y,
  input  logic [tsdf_pkg::IDX_W-1:0]  grid_z,
  output logic                        done,
  output logic signed [31:0]          sample_value,
  output logic [tsdf_pkg::ADDR_W-1:0] sample_address,
  output logic                        index_out_of_range,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tsdf_pkg::*;

  cfg_t cfg;

  // Request capture stage.
  logic             v1;
  logic [IDX_W-1:0] gx1, gy1, gz1;

  // Point stage outputs.
  logic               v2;
  logic signed [31:0] px2, py2, pz2;
  logic [ADDR_W-1:0]  addr2;
  logic               oor2;

  // Squares and sums.
  logic [31:0] mx, my, mz;
  logic [63:0] sqx3, sqy3, sum4;
  logic [31:0] radial;
  logic [30:0] radial_sat;
  logic signed [32:0] q_diff;
  logic [31:0] mq21;
  logic [63:0] mq22, sum23;
  logic [31:0] len;
  logic signed [33:0] val;

  side_t line [LINE_LEN];

  assign busy   = 1'b0;
  assign pready = 1'b1;

  tsdf_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
  end

  always_ff @(posedge clk) begin
    gx1 <= grid_x;
    gy1 <= grid_y;
    gz1 <= grid_z;
  end

  tsdf_point u_point (
    .clk, .rst, .in_valid(v1), .gx(gx1), .gy(gy1), .gz(gz1), .cfg,
    .out_valid(v2), .px(px2), .py(py2), .pz(pz2), .addr(addr2), .oor(oor2)
  );

  // Magnitudes fit in 32 bits, including the most negative coordinate.
  always_comb begin
    mx = px2[31] ? 32'(-33'(px2)) : px2;
    my = py2[31] ? 32'(-33'(py2)) : py2;
    mz = pz2[31] ? 32'(-33'(pz2)) : pz2;
  end

  always_ff @(posedge clk) begin
    sqx3 <= mx * mx;
    sqy3 <= my * my;
    sum4 <= sqx3 + sqy3;
  end

  // Side band line: valid, address, flag and the z square travel together.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE_LEN; i++) line[i].valid <= 1'b0;
    end else begin
      line[0].valid <= v2;
      for (int i = 1; i < LINE_LEN; i++) line[i].valid <= line[i-1].valid;
    end
    line[0].addr <= addr2;
    line[0].oor  <= oor2;
    line[0].sqz  <= mz * mz;
    for (int i = 1; i < LINE_LEN; i++) begin
      line[i].addr <= line[i-1].addr;
      line[i].oor  <= line[i-1].oor;
      line[i].sqz  <= line[i-1].sqz;
    end
  end

  tsdf_sqrt u_sqrt_radial (.clk, .din(sum4), .root(radial));

  // Radial length clamps to the Q16.16 maximum before the major radius is removed.
  always_comb begin
    radial_sat = radial[31] ? 31'h7FFF_FFFF : radial[30:0];
    q_diff     = $signed({2'b00, radial_sat}) - $signed({4'd0, cfg.resolution[30:2]});
  end

  always_ff @(posedge clk) begin
    mq21  <= q_diff[32] ? 32'(-q_diff) : q_diff[31:0];
    mq22  <= mq21 * mq21;
    sum23 <= mq22 + line[2*0 + SQRT_STAGES + 3].sqz;
  end

  tsdf_sqrt u_sqrt_len (.clk, .din(sum23), .root(len));

  assign val = $signed({6'd0, cfg.small_r}) - $signed({2'b00, len});

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= line[LINE_LEN-1].valid;
  end

  always_ff @(posedge clk) begin
    if (val < -34'sh0_8000_0000) sample_value <= 32'sh8000_0000;
    else                         sample_value <= val[31:0];
    sample_address     <= line[LINE_LEN-1].addr;
    index_out_of_range <= line[LINE_LEN-1].oor;
  end
endmodule

[sim/tb_torus_sdf_grid_sampler_top.sv]
// Self-checking testbench for the torus signed distance grid sampler.
module tb_torus_sdf_grid_sampler_top;
  import tsdf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog allows for the result latency, the longest request gap and
  // the configuration writes many times over.
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic signed [31:0] value;
    logic [ADDR_W-1:0]  address;
    logic               oor;
  } sample_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [IDX_W-1:0]     grid_x = '0;
  logic [IDX_W-1:0]     grid_y = '0;
  logic [IDX_W-1:0]     grid_z = '0;
  logic                 done;
  logic signed [31:0]   sample_value;
  logic [ADDR_W-1:0]    sample_address;
  logic                 index_out_of_range;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [4:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Local copy of the register file, updated as each write lands.
  logic signed [31:0]   cfg_origin [3];
  logic [30:0]          cfg_step;
  logic [30:0]          cfg_resolution;
  logic [SIZE_W-1:0]    cfg_size [3];

  sample_t              pending_samples [$];
  int                   n_requests = 0;
  int                   n_results = 0;
  int                   n_errors = 0;
  int                   n_writes = 0;
  int                   quiet_cycles = 0;
  bit                   burst_mode = 1'b0;

  torus_sdf_grid_sampler_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .grid_x(grid_x), .grid_y(grid_y), .grid_z(grid_z),
    .done(done), .sample_value(sample_value), .sample_address(sample_address),
    .index_out_of_range(index_out_of_range),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Floor integer square root, one result bit per pass.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic longint clamp_q16(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned abs_u(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned clip_size(logic [SIZE_W-1:0] s);
    return (s > SIZE_W'(MAX_DIM)) ? 64'(MAX_DIM) : 64'(s);
  endfunction

  // Expected sample for one index triple under the current register file.
  function automatic sample_t torus_sample(logic [IDX_W-1:0] gx, logic [IDX_W-1:0] gy,
                                           logic [IDX_W-1:0] gz);
    sample_t         s;
    longint          p [3];
    longint unsigned m [3];
    longint unsigned radial, len, sx, sy, sz;
    longint          big_r, small_r, dq;
    longint unsigned idx [3];
    idx[0] = 64'(gx);
    idx[1] = 64'(gy);
    idx[2] = 64'(gz);
    for (int a = 0; a < 3; a++) begin
      p[a] = clamp_q16(longint'(cfg_origin[a]) + longint'(idx[a]) * longint'(cfg_step));
      m[a] = abs_u(p[a]);
    end
    big_r   = longint'(cfg_resolution >> 2);
    small_r = longint'(cfg_resolution / 10);
    radial  = int_sqrt(m[0] * m[0] + m[1] * m[1]);
    if (radial > 64'd2147483647) radial = 64'd2147483647;
    dq  = longint'(radial) - big_r;
    len = int_sqrt(abs_u(dq) * abs_u(dq) + m[2] * m[2]);
    sx = clip_size(cfg_size[0]);
    sy = clip_size(cfg_size[1]);
    sz = clip_size(cfg_size[2]);
    s.value   = 32'(clamp_q16(small_r - longint'(len)));
    s.address = ADDR_W'(idx[0] * sy * sz + idx[1] * sz + idx[2]);
    s.oor     = (idx[0] >= sx) || (idx[1] >= sy) || (idx[2] >= sz);
    return s;
  endfunction

  // Record each accepted request and check each result against the oldest
  // outstanding sample. Sampling at the rising edge sees settled values.
  always @(posedge clk) begin
    sample_t want;
    bit      moved;
    if (!rst) begin
      moved = done || (start && !busy) || (psel && penable);
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (done) begin
        n_results++;
        if (pending_samples.size() == 0) begin
          $error("result with no outstanding request: value %0d address %0d",
                 sample_value, sample_address);
          n_errors++;
        end else begin
          want = pending_samples.pop_front();
          if (sample_value !== want.value) begin
            $error("sample_value expected %0d actual %0d", want.value, sample_value);
            n_errors++;
          end
          if (sample_address !== want.address) begin
            $error("sample_address expected %0d actual %0d", want.address, sample_address);
            n_errors++;
          end
          if (index_out_of_range !== want.oor) begin
            $error("index_out_of_range expected %0b actual %0b", want.oor,
                   index_out_of_range);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        n_requests++;
        pending_samples.push_back(torus_sample(grid_x, grid_y, grid_z));
      end
    end
  end

  // The watchdog ends a run in which nothing moves for too long.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d samples outstanding", pending_samples.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Issue one request after a random gap; gaps vanish during bursts so that
  // back-to-back requests keep start high across cycles.
  task automatic send_index(int gx, int gy, int gz);
    int gap;
    if ($urandom_range(0, 19) == 0) burst_mode = !burst_mode;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    grid_x <= IDX_W'(gx);
    grid_y <= IDX_W'(gy);
    grid_z <= IDX_W'(gz);
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  // Drop start and wait until every outstanding sample has come back, plus
  // the pipeline depth, so that register writes land on an idle block.
  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write in setup and access phases; the local copy follows at the access edge.
  task automatic write_register(reg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 2;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_ORIGIN_X:   cfg_origin[0]  = data;
      REG_ORIGIN_Y:   cfg_origin[1]  = data;
      REG_ORIGIN_Z:   cfg_origin[2]  = data;
      REG_STEP:       cfg_step       = data[30:0];
      REG_RESOLUTION: cfg_resolution = data[30:0];
      REG_SIZE_X:     cfg_size[0]    = data[SIZE_W-1:0];
      REG_SIZE_Y:     cfg_size[1]    = data[SIZE_W-1:0];
      REG_SIZE_Z:     cfg_size[2]    = data[SIZE_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_config(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [31:0] stp, logic [31:0] res,
                             logic [31:0] nx, logic [31:0] ny, logic [31:0] nz);
    drain_pipeline();
    write_register(REG_ORIGIN_X, ox);
    write_register(REG_ORIGIN_Y, oy);
    write_register(REG_ORIGIN_Z, oz);
    write_register(REG_STEP, stp);
    write_register(REG_RESOLUTION, res);
    write_register(REG_SIZE_X, nx);
    write_register(REG_SIZE_Y, ny);
    write_register(REG_SIZE_Z, nz);
  endtask

  // Corner and interior indices under the reset register values.
  task automatic test_reset_defaults();
    send_index(0, 0, 0);
    send_index(63, 63, 63);
    send_index(63, 0, 0);
    send_index(0, 63, 0);
    send_index(0, 0, 63);
    send_index(32, 32, 0);
    send_index(48, 32, 32);
  endtask

  // Saturating points, zero and oversize grid dimensions, degenerate radii.
  task automatic test_extreme_config();
    // Largest origin and step: every coordinate saturates high.
    load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                32'h7FFF_FFFF, 0, 0, 0);
    send_index(0, 0, 0);
    send_index(63, 63, 63);
    send_index(1, 0, 0);
    // Most negative origin with a zero step and zero resolution.
    load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 127, 65, 64);
    send_index(0, 0, 0);
    send_index(63, 63, 63);
    send_index(63, 0, 17);
    // A one-cell grid, so every index but the origin index is out of range.
    load_config(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 1, 1, 1);
    send_index(0, 0, 0);
    send_index(0, 1, 0);
    send_index(63, 63, 63);
    send_index(0, 0, 63);
  endtask

  // Random phases: mostly a torus centred in a sensible grid, sometimes
  // anything the registers allow.
  task automatic test_random_grids(int phases, int per_phase);
    logic [31:0] stp, res, ox, oy, oz;
    logic [31:0] nx, ny, nz;
    for (int ph = 0; ph < phases; ph++) begin
      if ($urandom_range(0, 3) != 0) begin
        stp = $urandom_range(1, 8) << $urandom_range(10, 17);
        res = stp * $urandom_range(8, 64);
        ox  = -(stp * $urandom_range(0, 40));
        oy  = -(stp * $urandom_range(0, 40));
        oz  = -(stp * $urandom_range(0, 40));
        nx  = $urandom_range(1, 64);
        ny  = $urandom_range(1, 64);
        nz  = $urandom_range(1, 64);
      end else begin
        stp = $urandom();
        res = $urandom();
        ox  = $urandom();
        oy  = $urandom();
        oz  = $urandom();
        nx  = $urandom_range(0, 127);
        ny  = $urandom_range(0, 127);
        nz  = $urandom_range(0, 127);
      end
      load_config(ox, oy, oz, stp, res, nx, ny, nz);
      for (int i = 0; i < per_phase; i++) begin
        send_index($urandom(), $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    cfg_origin[0]  = '0;
    cfg_origin[1]  = '0;
    cfg_origin[2]  = '0;
    cfg_step       = 31'd65536;
    cfg_resolution = 31'd4194304;
    cfg_size[0]    = 7'd64;
    cfg_size[1]    = 7'd64;
    cfg_size[2]    = 7'd64;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_extreme_config();
    test_random_grids(10, 85);

    drain_pipeline();
    $display("Covered %0d requests and %0d results across %0d register writes,",
             n_requests, n_results, n_writes);
    $display("including saturated points, zero and oversize grids, and random gaps.");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
